### hw/rtl/segx_pkg.sv
package segx_pkg;

  // Default coordinate width (signed Q4.12 at 16 bits)
  localparam int unsigned CoordWidth = 16;

  // Result status codes
  localparam logic [1:0] StatusHit      = 2'd0;
  localparam logic [1:0] StatusMiss     = 2'd1;
  localparam logic [1:0] StatusParallel = 2'd2;

endpackage

### hw/rtl/segx_if.sv
// Input channel: two segments, four endpoints
interface segx_in_if #(
  parameter int unsigned W = segx_pkg::CoordWidth
);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] a_start_x;
  logic signed [W-1:0] a_start_y;
  logic signed [W-1:0] a_end_x;
  logic signed [W-1:0] a_end_y;
  logic signed [W-1:0] b_start_x;
  logic signed [W-1:0] b_start_y;
  logic signed [W-1:0] b_end_x;
  logic signed [W-1:0] b_end_y;

  modport source (
    output valid, a_start_x, a_start_y, a_end_x, a_end_y,
           b_start_x, b_start_y, b_end_x, b_end_y,
    input  ready
  );
  modport sink (
    input  valid, a_start_x, a_start_y, a_end_x, a_end_y,
           b_start_x, b_start_y, b_end_x, b_end_y,
    output ready
  );
endinterface

// Output channel: status and crossing point
interface segx_out_if #(
  parameter int unsigned W = segx_pkg::CoordWidth
);
  logic                valid;
  logic                ready;
  logic [1:0]          status;
  logic signed [W-1:0] cross_x;
  logic signed [W-1:0] cross_y;

  modport source (output valid, status, cross_x, cross_y, input ready);
  modport sink   (input  valid, status, cross_x, cross_y, output ready);
endinterface

### hw/rtl/segment_intersection_core.sv
// Channel   Dir  Modport  Transaction
// in_i      in   sink     two segments: a_start/a_end, b_start/b_end (x, y)
// out_o     out  source   status, cross_x, cross_y
//
// One transaction per cycle while out_o does not stall.
// Depth set by the restoring divider: one quotient bit per stage.
// Every stage holds its own valid bit and fills bubbles; a stall at out_o
// backs up stage by stage, nothing lost or repeated.
// rst_ni clears the valid bits only; no state beyond the pipeline.
module segment_intersection_core #(
  parameter int unsigned COORD_WIDTH = segx_pkg::CoordWidth
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  segx_in_if.sink    in_i,
  segx_out_if.source out_o
);

  localparam int unsigned W  = COORD_WIDTH;
  localparam int unsigned DW = W + 1;       // differences
  localparam int unsigned PW = 2 * W + 2;   // difference products
  localparam int unsigned NW = 2 * W + 3;   // denominator, numerators
  localparam int unsigned MW = 3 * W + 4;   // numerator times difference
  localparam int unsigned QW = W + 1;       // quotient magnitude
  localparam int unsigned SW = 2 * W + 4;   // status, ax1, ay1, signs
  localparam int unsigned CW = W + 2;       // final sum

  // ---------------- stage 1: differences and products ----------------
  logic signed [DW-1:0] adx, ady, bdx, bdy, ox, oy;
  logic                 v1_q, rdy1, rdy2;
  logic signed [PW-1:0] p_dena_q, p_denb_q, p_naa_q, p_nab_q, p_nba_q, p_nbb_q;
  logic signed [DW-1:0] adx1_q, ady1_q;
  logic signed [W-1:0]  ax1_1_q, ay1_1_q;

  assign adx = DW'(in_i.a_end_x) - DW'(in_i.a_start_x);
  assign ady = DW'(in_i.a_end_y) - DW'(in_i.a_start_y);
  assign bdx = DW'(in_i.b_end_x) - DW'(in_i.b_start_x);
  assign bdy = DW'(in_i.b_end_y) - DW'(in_i.b_start_y);
  assign ox  = DW'(in_i.a_start_x) - DW'(in_i.b_start_x);
  assign oy  = DW'(in_i.a_start_y) - DW'(in_i.b_start_y);

  assign rdy1       = !v1_q || rdy2;
  assign in_i.ready = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (rdy1) begin
      v1_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && in_i.valid) begin
      p_dena_q <= PW'(bdy) * PW'(adx);
      p_denb_q <= PW'(bdx) * PW'(ady);
      p_naa_q  <= PW'(bdx) * PW'(oy);
      p_nab_q  <= PW'(bdy) * PW'(ox);
      p_nba_q  <= PW'(adx) * PW'(oy);
      p_nbb_q  <= PW'(ady) * PW'(ox);
      adx1_q   <= adx;
      ady1_q   <= ady;
      ax1_1_q  <= in_i.a_start_x;
      ay1_1_q  <= in_i.a_start_y;
    end
  end

  // ---------------- stage 2: denominator and numerators ----------------
  logic                 v2_q, rdy3;
  logic signed [NW-1:0] den2_q, num_a2_q, num_b2_q;
  logic signed [DW-1:0] adx2_q, ady2_q;
  logic signed [W-1:0]  ax1_2_q, ay1_2_q;

  assign rdy2 = !v2_q || rdy3;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (rdy2) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy2 && v1_q) begin
      den2_q   <= NW'(p_dena_q) - NW'(p_denb_q);
      num_a2_q <= NW'(p_naa_q) - NW'(p_nab_q);
      num_b2_q <= NW'(p_nba_q) - NW'(p_nbb_q);
      adx2_q   <= adx1_q;
      ady2_q   <= ady1_q;
      ax1_2_q  <= ax1_1_q;
      ay1_2_q  <= ay1_1_q;
    end
  end

  // ---------------- stage 3: range test and scaled numerators ----------------
  logic [NW-1:0]        den_mag, na_mag, nb_mag;
  logic                 a_in, b_in;
  logic [1:0]           status3;
  logic                 v3_q, rdy4;
  logic [1:0]           status3_q;
  logic signed [MW-1:0] mx3_q, my3_q;
  logic signed [NW-1:0] den3_q;
  logic signed [W-1:0]  ax1_3_q, ay1_3_q;

  assign den_mag = den2_q[NW-1]   ? -den2_q   : den2_q;
  assign na_mag  = num_a2_q[NW-1] ? -num_a2_q : num_a2_q;
  assign nb_mag  = num_b2_q[NW-1] ? -num_b2_q : num_b2_q;

  // Parameter in [0,1]: zero, or same sign and not larger than denominator
  assign a_in = (num_a2_q == '0) ||
                ((num_a2_q[NW-1] == den2_q[NW-1]) && (na_mag <= den_mag));
  assign b_in = (num_b2_q == '0) ||
                ((num_b2_q[NW-1] == den2_q[NW-1]) && (nb_mag <= den_mag));

  always_comb begin
    if (den2_q == '0) begin
      status3 = segx_pkg::StatusParallel;
    end else if (a_in && b_in) begin
      status3 = segx_pkg::StatusHit;
    end else begin
      status3 = segx_pkg::StatusMiss;
    end
  end

  assign rdy3 = !v3_q || rdy4;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (rdy3) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy3 && v2_q) begin
      status3_q <= status3;
      mx3_q     <= MW'(num_a2_q) * MW'(adx2_q);
      my3_q     <= MW'(num_a2_q) * MW'(ady2_q);
      den3_q    <= den2_q;
      ax1_3_q   <= ax1_2_q;
      ay1_3_q   <= ay1_2_q;
    end
  end

  // ---------------- stage 4: magnitudes for the divider ----------------
  logic          v4_q;
  logic [MW-1:0] rem4_x_q, rem4_y_q;
  logic [NW-1:0] dm4_q;
  logic [SW-1:0] side4_q;
  logic          dv_valid [QW+1];
  logic          dv_ready [QW+1];
  logic [MW-1:0] dv_rem_x [QW+1];
  logic [MW-1:0] dv_rem_y [QW+1];
  logic [NW-1:0] dv_dm    [QW+1];
  logic [QW-1:0] dv_q_x   [QW+1];
  logic [QW-1:0] dv_q_y   [QW+1];
  logic [SW-1:0] dv_side  [QW+1];

  assign rdy4 = !v4_q || dv_ready[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (rdy4) begin
      v4_q <= v3_q;
    end
  end

  // side = {status, ax1, ay1, neg_x, neg_y}
  always_ff @(posedge clk_i) begin
    if (rdy4 && v3_q) begin
      rem4_x_q <= mx3_q[MW-1] ? -mx3_q : mx3_q;
      rem4_y_q <= my3_q[MW-1] ? -my3_q : my3_q;
      dm4_q    <= den3_q[NW-1] ? -den3_q : den3_q;
      side4_q  <= {status3_q, ax1_3_q, ay1_3_q,
                   mx3_q[MW-1] ^ den3_q[NW-1], my3_q[MW-1] ^ den3_q[NW-1]};
    end
  end

  assign dv_valid[0] = v4_q;
  assign dv_rem_x[0] = rem4_x_q;
  assign dv_rem_y[0] = rem4_y_q;
  assign dv_dm[0]    = dm4_q;
  assign dv_q_x[0]   = '0;
  assign dv_q_y[0]   = '0;
  assign dv_side[0]  = side4_q;

  // ---------------- divider: one quotient bit per stage, MSB first ----------------
  for (genvar j = 0; j < QW; j++) begin : g_div
    segx_div_step #(
      .RW    (MW),
      .NW    (NW),
      .QW    (QW),
      .SW    (SW),
      .SHIFT (QW - 1 - j)
    ) u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (dv_valid[j]),
      .ready_o (dv_ready[j]),
      .rem_x_i (dv_rem_x[j]),
      .rem_y_i (dv_rem_y[j]),
      .dm_i    (dv_dm[j]),
      .q_x_i   (dv_q_x[j]),
      .q_y_i   (dv_q_y[j]),
      .side_i  (dv_side[j]),
      .valid_o (dv_valid[j+1]),
      .ready_i (dv_ready[j+1]),
      .rem_x_o (dv_rem_x[j+1]),
      .rem_y_o (dv_rem_y[j+1]),
      .dm_o    (dv_dm[j+1]),
      .q_x_o   (dv_q_x[j+1]),
      .q_y_o   (dv_q_y[j+1]),
      .side_o  (dv_side[j+1])
    );
  end

  // ---------------- output register: sign, offset, masking ----------------
  logic                 out_v_q, out_rdy;
  logic [1:0]           st_f;
  logic signed [W-1:0]  ax1_f, ay1_f;
  logic                 neg_x_f, neg_y_f;
  logic signed [CW-1:0] qs_x, qs_y, sum_x, sum_y;
  logic [1:0]           status_q;
  logic signed [W-1:0]  cross_x_q, cross_y_q;

  assign {st_f, ax1_f, ay1_f, neg_x_f, neg_y_f} = dv_side[QW];

  assign qs_x  = neg_x_f ? -CW'($signed({1'b0, dv_q_x[QW]})) : CW'($signed({1'b0, dv_q_x[QW]}));
  assign qs_y  = neg_y_f ? -CW'($signed({1'b0, dv_q_y[QW]})) : CW'($signed({1'b0, dv_q_y[QW]}));
  assign sum_x = CW'(ax1_f) + qs_x;
  assign sum_y = CW'(ay1_f) + qs_y;

  assign out_rdy      = !out_v_q || out_o.ready;
  assign dv_ready[QW] = out_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_rdy) begin
      out_v_q <= dv_valid[QW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_rdy && dv_valid[QW]) begin
      status_q <= st_f;
      if (st_f == segx_pkg::StatusHit) begin
        cross_x_q <= sum_x[W-1:0];
        cross_y_q <= sum_y[W-1:0];
      end else begin
        cross_x_q <= '0;
        cross_y_q <= '0;
      end
    end
  end

  assign out_o.valid   = out_v_q;
  assign out_o.status  = status_q;
  assign out_o.cross_x = cross_x_q;
  assign out_o.cross_y = cross_y_q;

endmodule

### hw/rtl/segx_div_step.sv
// One restoring-division step for x and y, with its own pipeline register
module segx_div_step #(
  parameter int unsigned RW    = 52,
  parameter int unsigned NW    = 35,
  parameter int unsigned QW    = 17,
  parameter int unsigned SW    = 36,
  parameter int unsigned SHIFT = 0
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          ready_o,
  input  logic [RW-1:0] rem_x_i,
  input  logic [RW-1:0] rem_y_i,
  input  logic [NW-1:0] dm_i,
  input  logic [QW-1:0] q_x_i,
  input  logic [QW-1:0] q_y_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  input  logic          ready_i,
  output logic [RW-1:0] rem_x_o,
  output logic [RW-1:0] rem_y_o,
  output logic [NW-1:0] dm_o,
  output logic [QW-1:0] q_x_o,
  output logic [QW-1:0] q_y_o,
  output logic [SW-1:0] side_o
);

  logic          valid_q;
  logic [RW-1:0] trial;
  logic [RW-1:0] rem_x_d, rem_y_d;
  logic [QW-1:0] q_x_d, q_y_d;
  logic [QW-1:0] bit_mask;

  assign ready_o  = !valid_q || ready_i;
  assign trial    = RW'(dm_i) << SHIFT;
  assign bit_mask = QW'(1) << SHIFT;

  // Subtract the shifted divisor where it fits
  always_comb begin
    rem_x_d = rem_x_i;
    rem_y_d = rem_y_i;
    q_x_d   = q_x_i;
    q_y_d   = q_y_i;
    if (rem_x_i >= trial) begin
      rem_x_d = rem_x_i - trial;
      q_x_d   = q_x_i | bit_mask;
    end
    if (rem_y_i >= trial) begin
      rem_y_d = rem_y_i - trial;
      q_y_d   = q_y_i | bit_mask;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      rem_x_o <= rem_x_d;
      rem_y_o <= rem_y_d;
      dm_o    <= dm_i;
      q_x_o   <= q_x_d;
      q_y_o   <= q_y_d;
      side_o  <= side_i;
    end
  end

  assign valid_o = valid_q;

endmodule

### tb/sv/segment_intersection_core_tb.sv
`timescale 1ns / 1ps

module segment_intersection_core_tb;

  localparam int unsigned W = segx_pkg::CoordWidth;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned DrainCycles = 2 * (W + 6) + 10;
  localparam int unsigned HoldOffCycles = 300;

  typedef logic signed [W-1:0] coord_t;

  typedef struct packed {
    coord_t ax1, ay1, ax2, ay2;
    coord_t bx1, by1, bx2, by2;
  } seg_pair_t;

  typedef struct packed {
    logic [1:0] status;
    coord_t     cross_x;
    coord_t     cross_y;
  } crossing_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  segx_in_if  #(.W(W)) in_if ();
  segx_out_if #(.W(W)) out_if ();

  segment_intersection_core #(.COORD_WIDTH(W)) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if.sink),
    .out_o  (out_if.source)
  );

  always #5 clk_i = ~clk_i;

  crossing_t   pending_crossings[$];
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned burst_left = 0;
  int unsigned hold_requests = 0;
  int unsigned hold_served = 0;
  int unsigned hold_left = 0;
  int unsigned stall_window = 0;
  int unsigned stall_mode = 0;

  // Exact integer crossing test, parameter range checked without division
  function automatic bit param_in_unit(longint num, longint den);
    longint mn, md;
    mn = (num < 0) ? -num : num;
    md = (den < 0) ? -den : den;
    if (num == 0) return 1'b1;
    if ((num < 0) != (den < 0)) return 1'b0;
    return mn <= md;
  endfunction

  function automatic crossing_t predict_crossing(seg_pair_t p);
    crossing_t r;
    longint adx, ady, bdx, bdy, ox, oy, den, num_a, num_b, cx, cy;
    adx = longint'(p.ax2) - longint'(p.ax1);
    ady = longint'(p.ay2) - longint'(p.ay1);
    bdx = longint'(p.bx2) - longint'(p.bx1);
    bdy = longint'(p.by2) - longint'(p.by1);
    ox  = longint'(p.ax1) - longint'(p.bx1);
    oy  = longint'(p.ay1) - longint'(p.by1);
    den = bdy * adx - bdx * ady;
    r = '0;
    if (den == 0) begin
      r.status = segx_pkg::StatusParallel;
      return r;
    end
    num_a = bdx * oy - bdy * ox;
    num_b = adx * oy - ady * ox;
    if (!param_in_unit(num_a, den) || !param_in_unit(num_b, den)) begin
      r.status = segx_pkg::StatusMiss;
      return r;
    end
    cx = longint'(p.ax1) + (num_a * adx) / den;
    cy = longint'(p.ay1) + (num_a * ady) / den;
    r.status  = segx_pkg::StatusHit;
    r.cross_x = cx[W-1:0];
    r.cross_y = cy[W-1:0];
    return r;
  endfunction

  // Sender: bursts of transactions with random gaps; runs from falling edges
  task automatic send_pair(seg_pair_t p);
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) begin
        in_if.valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk_i);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? 60 : $urandom_range(1, 16);
    end
    in_if.valid     <= 1'b1;
    in_if.a_start_x <= p.ax1;
    in_if.a_start_y <= p.ay1;
    in_if.a_end_x   <= p.ax2;
    in_if.a_end_y   <= p.ay2;
    in_if.b_start_x <= p.bx1;
    in_if.b_start_y <= p.by1;
    in_if.b_end_x   <= p.bx2;
    in_if.b_end_y   <= p.by2;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    pending_crossings.push_back(predict_crossing(p));
    burst_left--;
    @(negedge clk_i);
  endtask

  function automatic seg_pair_t make_pair(int ax1, int ay1, int ax2, int ay2,
                                          int bx1, int by1, int bx2, int by2);
    seg_pair_t p;
    p.ax1 = coord_t'(ax1); p.ay1 = coord_t'(ay1);
    p.ax2 = coord_t'(ax2); p.ay2 = coord_t'(ay2);
    p.bx1 = coord_t'(bx1); p.by1 = coord_t'(by1);
    p.bx2 = coord_t'(bx2); p.by2 = coord_t'(by2);
    return p;
  endfunction

  function automatic coord_t rand_coord();
    return coord_t'($urandom);
  endfunction

  // Receiver: ready pattern changes every window; long hold-off on request
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else if (hold_left != 0) begin
      out_if.ready <= 1'b0;
      hold_left = hold_left - 1;
    end else if (hold_served != hold_requests) begin
      hold_served = hold_served + 1;
      hold_left = HoldOffCycles;
      out_if.ready <= 1'b0;
    end else begin
      if (stall_window == 0) begin
        stall_window = $urandom_range(20, 120);
        stall_mode = $urandom_range(0, 2);
      end
      stall_window = stall_window - 1;
      case (stall_mode)
        0: out_if.ready <= 1'b1;
        1: out_if.ready <= ($urandom_range(0, 3) != 0);
        default: out_if.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Result checker against the oldest expectation
  always @(posedge clk_i) begin
    crossing_t exp_r;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pending_crossings.size() == 0) begin
        $error("unexpected result transaction: status %0d", out_if.status);
        error_count++;
      end else begin
        exp_r = pending_crossings.pop_front();
        if (out_if.status !== exp_r.status) begin
          $error("status: expected %0d, got %0d", exp_r.status, out_if.status);
          error_count++;
        end
        if (out_if.cross_x !== exp_r.cross_x) begin
          $error("cross_x: expected %0d, got %0d", exp_r.cross_x, out_if.cross_x);
          error_count++;
        end
        if (out_if.cross_y !== exp_r.cross_y) begin
          $error("cross_y: expected %0d, got %0d", exp_r.cross_y, out_if.cross_y);
          error_count++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Corners: parallel, degenerate, collinear, touching ends, extremes
  task automatic test_directed();
    send_pair(make_pair(0, 0, 4096, 4096, 0, 4096, 4096, 0));
    send_pair(make_pair(0, 0, 4096, 0, 0, 4096, 4096, 4096));
    send_pair(make_pair(100, 100, 100, 100, -5, 3, 7, 9));
    send_pair(make_pair(0, 0, 0, 0, 0, 0, 0, 0));
    send_pair(make_pair(0, 0, 4096, 0, 2048, 0, 8192, 0));
    send_pair(make_pair(0, 0, 4096, 0, 4096, 0, 4096, 4096));
    send_pair(make_pair(0, 0, 4096, 0, 0, 0, 0, -4096));
    send_pair(make_pair(0, 0, 4096, 0, 2048, 1, 2048, 4096));
    send_pair(make_pair(0, 0, 4096, 0, 5000, -100, 5000, 100));
    send_pair(make_pair(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768));
    send_pair(make_pair(32767, -32768, -32768, 32767, -32768, -32768, 32767, 32767));
    send_pair(make_pair(-32768, 0, 32767, 0, 0, -32768, 0, 32767));
    send_pair(make_pair(-32768, -32768, -32768, 32767, 32767, -32768, 32767, 32767));
    send_pair(make_pair(-32768, -32768, 32767, 32767, -32768, -32768, 32767, 32767));
    send_pair(make_pair(1, 0, -1, 3, -3, 1, 5, 2));
    send_pair(make_pair(-7, -7, 9, 11, 9, -7, -7, 11));
    send_pair(make_pair(0, 0, 3, 1, 3, 0, 0, 1));
    send_pair(make_pair(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
    send_pair(make_pair(-32768, -32768, 32767, -32767, -32768, 32767, 32767, -32768));
  endtask

  // Segment B is built through a point on or near A, so most pairs hit
  task automatic test_random_crossings(int unsigned count);
    seg_pair_t p;
    longint t, px, py, dx, dy, k;
    repeat (count) begin
      p.ax1 = ($urandom_range(0, 7) == 0) ? rand_coord() : coord_t'($urandom_range(0, 16383) - 8192);
      p.ay1 = ($urandom_range(0, 7) == 0) ? rand_coord() : coord_t'($urandom_range(0, 16383) - 8192);
      p.ax2 = coord_t'($urandom_range(0, 32767) - 16384);
      p.ay2 = coord_t'($urandom_range(0, 32767) - 16384);
      t  = $urandom_range(0, 1024);
      px = longint'(p.ax1) + (longint'(p.ax2) - longint'(p.ax1)) * t / 1024;
      py = longint'(p.ay1) + (longint'(p.ay2) - longint'(p.ay1)) * t / 1024;
      dx = longint'($urandom_range(0, 8191)) - 4096;
      dy = longint'($urandom_range(0, 8191)) - 4096;
      k  = $urandom_range(0, 4);
      p.bx1 = coord_t'(px + dx);
      p.by1 = coord_t'(py + dy);
      p.bx2 = coord_t'(px - dx * k);
      p.by2 = coord_t'(py - dy * k);
      if ($urandom_range(0, 15) == 0) begin
        p.bx2 = p.bx1 + (p.ax2 - p.ax1);
        p.by2 = p.by1 + (p.ay2 - p.ay1);
      end
      send_pair(p);
    end
  endtask

  // Full-range noise: every bit of every coordinate toggles
  task automatic test_random_noise(int unsigned count);
    seg_pair_t p;
    repeat (count) begin
      p = {$urandom, $urandom, $urandom, $urandom};
      send_pair(p);
    end
  endtask

  // Receiver holds off while the sender keeps offering back to back
  task automatic test_backpressure();
    hold_requests++;
    burst_left = 200;
    test_random_crossings(120);
  endtask

  initial begin
    in_if.valid     = 1'b0;
    in_if.a_start_x = '0;
    in_if.a_start_y = '0;
    in_if.a_end_x   = '0;
    in_if.a_end_y   = '0;
    in_if.b_start_x = '0;
    in_if.b_start_y = '0;
    in_if.b_end_x   = '0;
    in_if.b_end_y   = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_directed();
    test_random_crossings(600);
    test_backpressure();
    test_random_noise(400);
    in_if.valid <= 1'b0;

    while (pending_crossings.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
